### hdl/drnm_pkg.sv
// Shared types and constants for the delta R nearest match core.
`timescale 1ns / 1ps

package drnm_pkg;

	localparam int ETA_W  = 12;
	localparam int PHI_W  = 11;
	localparam int ID_W   = 16;
	localparam int DIST_W = 26;
	localparam int SQ_W   = 25;

	localparam logic signed [PHI_W:0] PI_FX     = 12'sd804;
	localparam logic signed [PHI_W:0] TWO_PI_FX = 12'sd1608;

	localparam logic [DIST_W-1:0] DIST_SENTINEL = 26'd33554432;
	localparam logic [DIST_W-1:0] CUT_RESET     = 26'd33554432;

	typedef enum logic [1:0] {
		OP_CLEAR      = 2'd0,
		OP_APPEND     = 2'd1,
		OP_MATCH_ONE  = 2'd2,
		OP_MATCH_PAIR = 2'd3
	} op_t;

	typedef struct packed {
		logic signed [ETA_W-1:0] eta;
		logic signed [PHI_W-1:0] phi;
		logic [ID_W-1:0]         id;
	} ref_entry_t;

	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [SQ_W-1:0]   dsq;
	} dist_res_t;

endpackage

### hdl/drnm_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module drnm_ram #(
	parameter int WIDTH = 39,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/drnm_dist.sv
// Pipelined squared delta R unit with phi wrap, shared over all table entries.
`timescale 1ns / 1ps

module drnm_dist import drnm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  ref_entry_t              entry,
	input  logic signed [ETA_W-1:0] q_eta,
	input  logic signed [PHI_W-1:0] q_phi,
	output dist_res_t               res,
	output logic                    busy
);

	logic signed [ETA_W:0]     de;
	logic signed [PHI_W:0]     dp_raw;
	logic signed [PHI_W:0]     dp_wrap;

	logic                      v_s1;
	logic signed [ETA_W:0]     de_s1;
	logic signed [PHI_W-1:0]   dp_s1;
	logic [ID_W-1:0]           id_s1;

	logic signed [2*ETA_W+1:0] de_prod;
	logic signed [2*PHI_W-1:0] dp_prod;

	logic                      v_s2;
	logic [2*ETA_W-1:0]        de_sq_s2;
	logic [2*PHI_W-3:0]        dp_sq_s2;
	logic [ID_W-1:0]           id_s2;

	always_comb begin
		de     = {entry.eta[ETA_W-1], entry.eta} - {q_eta[ETA_W-1], q_eta};
		dp_raw = {entry.phi[PHI_W-1], entry.phi} - {q_phi[PHI_W-1], q_phi};
		if (dp_raw > PI_FX) begin
			dp_wrap = dp_raw - TWO_PI_FX;
		end else if (dp_raw < -PI_FX) begin
			dp_wrap = dp_raw + TWO_PI_FX;
		end else begin
			dp_wrap = dp_raw;
		end
	end

	assign de_prod = de_s1 * de_s1;
	assign dp_prod = dp_s1 * dp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		de_s1    <= de;
		dp_s1    <= dp_wrap[PHI_W-1:0];
		id_s1    <= entry.id;
		de_sq_s2 <= de_prod[2*ETA_W-1:0];
		dp_sq_s2 <= dp_prod[2*PHI_W-3:0];
		id_s2    <= id_s1;
	end

	assign res.valid = v_s2;
	assign res.id    = id_s2;
	assign res.dsq   = {1'b0, de_sq_s2} + {{(SQ_W-2*PHI_W+2){1'b0}}, dp_sq_s2};
	assign busy      = v_s1 | v_s2;

endmodule

### hdl/delta_r_nearest_match_core.sv
// Top level: reference table, walk sequencer and result registers.
// Append: done strobes in the cycle after the item is taken. Clear: no result.
// Match one walks the stored entries once and match pair twice, both through
// the single distance unit, which takes one table entry per cycle.
// Reset empties the table and loads the cut with 2^25; the receiver cannot stall.
`timescale 1ns / 1ps

module delta_r_nearest_match_core import drnm_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              op,
	input  logic signed [ETA_W-1:0] eta_a,
	input  logic signed [PHI_W-1:0] phi_a,
	input  logic signed [ETA_W-1:0] eta_b,
	input  logic signed [PHI_W-1:0] phi_b,
	input  logic [ID_W-1:0]         entry_tag,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [DIST_W-1:0]       cut_distance_sq,
	output logic                    done,
	output logic                    matched,
	output logic [ID_W-1:0]         best_id,
	output logic [DIST_W-1:0]       best_distance_sq,
	output logic                    pair_ok,
	output logic                    table_full
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           addr_q;
	logic [DIST_W-1:0]       cut_q;
	logic                    pass_q;
	logic                    pair_q;
	logic                    rd_v_q;
	logic [DIST_W-1:0]       best_q;
	logic [ID_W-1:0]         bid_q;
	logic                    m_a_q;
	logic [ID_W-1:0]         id_a_q;
	logic [DIST_W-1:0]       dist_a_q;
	logic signed [ETA_W-1:0] eta_a_q;
	logic signed [PHI_W-1:0] phi_a_q;
	logic signed [ETA_W-1:0] eta_b_q;
	logic signed [PHI_W-1:0] phi_b_q;

	logic                    accept;
	logic                    wr_en;
	logic                    rd_en;
	ref_entry_t              wr_entry;
	ref_entry_t              rd_entry;
	logic [$bits(ref_entry_t)-1:0] rd_data;
	logic signed [ETA_W-1:0] q_eta;
	logic signed [PHI_W-1:0] q_phi;
	dist_res_t               dres;
	logic                    dist_busy;
	logic                    walk_end;
	logic                    cur_match;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign wr_en     = accept && (op_t'(op) == OP_APPEND) && (count_q != DEPTH_CNT);
	assign rd_en     = (state_q == ST_WALK) && (addr_q != count_q);
	assign wr_entry  = '{eta: eta_a, phi: phi_a, id: entry_tag};
	assign rd_entry  = ref_entry_t'(rd_data);
	assign q_eta     = pass_q ? eta_b_q : eta_a_q;
	assign q_phi     = pass_q ? phi_b_q : phi_a_q;
	assign walk_end  = (addr_q == count_q) && !rd_v_q && !dist_busy;
	assign cur_match = (count_q != '0) && (best_q < cut_q);

	drnm_ram #(
		.WIDTH ($bits(ref_entry_t)),
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (addr_q[AW-1:0]),
		.rd_data (rd_data)
	);

	drnm_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_v_q),
		.entry    (rd_entry),
		.q_eta    (q_eta),
		.q_phi    (q_phi),
		.res      (dres),
		.busy     (dist_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			addr_q  <= '0;
			cut_q   <= CUT_RESET;
			pass_q  <= 1'b0;
			pair_q  <= 1'b0;
			rd_v_q  <= 1'b0;
			done    <= 1'b0;
		end else begin
			done   <= 1'b0;
			rd_v_q <= rd_en;
			if (cfg_valid && cfg_ready) begin
				cut_q <= cut_distance_sq;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (op_t'(op))
							OP_CLEAR: begin
								count_q <= '0;
							end
							OP_APPEND: begin
								done             <= 1'b1;
								matched          <= 1'b0;
								best_id          <= '0;
								best_distance_sq <= '0;
								pair_ok          <= 1'b0;
								table_full       <= (count_q == DEPTH_CNT);
								if (count_q != DEPTH_CNT) begin
									count_q <= count_q + 1'b1;
								end
							end
							OP_MATCH_ONE, OP_MATCH_PAIR: begin
								eta_a_q <= eta_a;
								phi_a_q <= phi_a;
								eta_b_q <= eta_b;
								phi_b_q <= phi_b;
								pair_q  <= (op_t'(op) == OP_MATCH_PAIR);
								pass_q  <= 1'b0;
								addr_q  <= '0;
								best_q  <= DIST_SENTINEL;
								bid_q   <= '0;
								state_q <= ST_WALK;
							end
							default: begin
								count_q <= count_q;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (rd_en) begin
						addr_q <= addr_q + 1'b1;
					end
					if (dres.valid && ({1'b0, dres.dsq} < best_q)) begin
						best_q <= {1'b0, dres.dsq};
						bid_q  <= dres.id;
					end
					if (walk_end) begin
						if (!pass_q) begin
							m_a_q    <= cur_match;
							id_a_q   <= bid_q;
							dist_a_q <= best_q;
							if (pair_q) begin
								pass_q <= 1'b1;
								addr_q <= '0;
								best_q <= DIST_SENTINEL;
								bid_q  <= '0;
							end else begin
								done             <= 1'b1;
								matched          <= cur_match;
								best_id          <= bid_q;
								best_distance_sq <= best_q;
								pair_ok          <= 1'b0;
								table_full       <= 1'b0;
								state_q          <= ST_IDLE;
							end
						end else begin
							done             <= 1'b1;
							matched          <= m_a_q;
							best_id          <= id_a_q;
							best_distance_sq <= dist_a_q;
							pair_ok          <= m_a_q && cur_match && (id_a_q != bid_q);
							table_full       <= 1'b0;
							state_q          <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
